// ===== design/ufd_pkg.sv =====
// Shared types, constants and helpers of the URL-encoded form decoder.
`timescale 1ns / 1ps

package ufd_pkg;

  // Field limits: a field keeps at most LIMIT bytes, that is BYTES-1.
  localparam int NAME_BYTES  = 1024;
  localparam int VALUE_BYTES = 4096;
  localparam int NAME_LEN_W  = $clog2(NAME_BYTES);
  localparam int VALUE_LEN_W = $clog2(VALUE_BYTES);
  localparam logic [NAME_LEN_W-1:0]  NAME_LIMIT  = NAME_LEN_W'(NAME_BYTES - 1);
  localparam logic [VALUE_LEN_W-1:0] VALUE_LIMIT = VALUE_LEN_W'(VALUE_BYTES - 1);

  localparam int PAIRS_W = 16;
  localparam logic [PAIRS_W-1:0] PAIRS_MAX = '1;

  // Queue between front and back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_NAME      = 3'd1,
    PH_AFTER_AMP = 3'd2,
    PH_VALUE     = 3'd3,
    PH_SWALLOW   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HI   = 2'd1,
    ESC_LO   = 2'd2
  } esc_t;

  // One queued job: one result, or a pair-complete followed by form done.
  typedef struct packed {
    logic               two;
    kind_t              kind;
    logic [7:0]         data;
    logic               in_value;
    logic [PAIRS_W-1:0] pairs;
  } entry_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== design/ufd_front.sv =====
// Front end: takes raw bytes, tracks the parse state and queues result jobs.
`timescale 1ns / 1ps

module ufd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             q_ready,
  output logic             push,
  output ufd_pkg::entry_t  push_entry
);

  ufd_pkg::phase_t                   phase, phase_next;
  ufd_pkg::esc_t                     esc, esc_next;
  logic [3:0]                        high_nibble, high_nibble_next;
  logic [ufd_pkg::NAME_LEN_W-1:0]    name_length, name_length_next;
  logic [ufd_pkg::VALUE_LEN_W-1:0]   value_length, value_length_next;
  logic [ufd_pkg::PAIRS_W-1:0]       pair_count, pair_count_next;

  logic                              accept;
  logic                              push_req;
  logic                              data_req;
  logic [7:0]                        data_ch;
  logic                              err;
  logic                              clear;
  logic [4:0]                        hx;
  logic [ufd_pkg::PAIRS_W-1:0]       pc_inc;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept && push_req;
  assign hx       = ufd_pkg::hex_decode(in_byte);
  assign pc_inc   = (pair_count == ufd_pkg::PAIRS_MAX) ? pair_count
                                                       : pair_count + 1'b1;

  always_comb begin
    phase_next        = phase;
    esc_next          = esc;
    high_nibble_next  = high_nibble;
    name_length_next  = name_length;
    value_length_next = value_length;
    pair_count_next   = pair_count;
    push_req          = 1'b0;
    push_entry        = '{two: 1'b0, kind: ufd_pkg::KIND_DATA, data: 8'h00,
                          in_value: 1'b0, pairs: pair_count};
    data_req          = 1'b0;
    data_ch           = ufd_pkg::CH_NUL;
    err               = 1'b0;
    clear             = 1'b0;

    if (phase == ufd_pkg::PH_SWALLOW) begin
      // drop everything up to the terminator
      if (in_byte == ufd_pkg::CH_NUL) clear = 1'b1;
    end else if (esc == ufd_pkg::ESC_HI) begin
      if (!hx[4]) begin
        err = 1'b1;
      end else begin
        high_nibble_next = hx[3:0];
        esc_next         = ufd_pkg::ESC_LO;
      end
    end else if (esc == ufd_pkg::ESC_LO) begin
      if (!hx[4]) begin
        err = 1'b1;
      end else begin
        esc_next = ufd_pkg::ESC_NONE;
        data_req = 1'b1;
        data_ch  = {high_nibble, hx[3:0]};
      end
    end else if (in_byte == ufd_pkg::CH_NUL) begin
      if (phase == ufd_pkg::PH_START) begin
        push_req        = 1'b1;
        push_entry.kind = ufd_pkg::KIND_DONE;
        clear           = 1'b1;
      end else if (phase == ufd_pkg::PH_VALUE) begin
        // pair complete, then form done with the same count
        push_req         = 1'b1;
        push_entry.two   = 1'b1;
        push_entry.kind  = ufd_pkg::KIND_PAIR;
        push_entry.pairs = pc_inc;
        clear            = 1'b1;
      end else begin
        err = 1'b1;
      end
    end else begin
      if (phase == ufd_pkg::PH_START || phase == ufd_pkg::PH_AFTER_AMP) begin
        phase_next       = ufd_pkg::PH_NAME;
        name_length_next = '0;
      end
      if (phase_next == ufd_pkg::PH_NAME && in_byte == ufd_pkg::CH_EQ) begin
        phase_next        = ufd_pkg::PH_VALUE;
        value_length_next = '0;
      end else if (phase_next == ufd_pkg::PH_VALUE && in_byte == ufd_pkg::CH_AMP) begin
        pair_count_next  = pc_inc;
        push_req         = 1'b1;
        push_entry.kind  = ufd_pkg::KIND_PAIR;
        push_entry.pairs = pc_inc;
        phase_next       = ufd_pkg::PH_AFTER_AMP;
        name_length_next = '0;
      end else if (in_byte == ufd_pkg::CH_PCT) begin
        esc_next = ufd_pkg::ESC_HI;
      end else if (in_byte == ufd_pkg::CH_PLUS) begin
        data_req = 1'b1;
        data_ch  = ufd_pkg::CH_SPACE;
      end else begin
        data_req = 1'b1;
        data_ch  = in_byte;
      end
    end

    if (err) begin
      push_req        = 1'b1;
      push_entry.kind = ufd_pkg::KIND_ERROR;
      if (in_byte == ufd_pkg::CH_NUL) begin
        clear = 1'b1;
      end else begin
        phase_next = ufd_pkg::PH_SWALLOW;
        esc_next   = ufd_pkg::ESC_NONE;
      end
    end

    // decoded zero and bytes past the field limit are dropped
    if (data_req && data_ch != ufd_pkg::CH_NUL) begin
      if (phase_next == ufd_pkg::PH_VALUE) begin
        if (value_length_next < ufd_pkg::VALUE_LIMIT) begin
          value_length_next   = value_length_next + 1'b1;
          push_req            = 1'b1;
          push_entry.data     = data_ch;
          push_entry.in_value = 1'b1;
        end
      end else begin
        if (name_length_next < ufd_pkg::NAME_LIMIT) begin
          name_length_next = name_length_next + 1'b1;
          push_req         = 1'b1;
          push_entry.data  = data_ch;
        end
      end
    end

    if (clear) begin
      phase_next        = ufd_pkg::PH_START;
      esc_next          = ufd_pkg::ESC_NONE;
      high_nibble_next  = '0;
      name_length_next  = '0;
      value_length_next = '0;
      pair_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ufd_pkg::PH_START;
      esc          <= ufd_pkg::ESC_NONE;
      high_nibble  <= '0;
      name_length  <= '0;
      value_length <= '0;
      pair_count   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      esc          <= esc_next;
      high_nibble  <= high_nibble_next;
      name_length  <= name_length_next;
      value_length <= value_length_next;
      pair_count   <= pair_count_next;
    end
  end

endmodule

// ===== design/ufd_queue.sv =====
// Short job queue between the decoder front end and the result stage.
`timescale 1ns / 1ps

module ufd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ufd_pkg::entry_t  push_entry,
  output logic             not_full,
  output logic             q_valid,
  output ufd_pkg::entry_t  q_entry,
  input  logic             pop
);

  ufd_pkg::entry_t               slots [ufd_pkg::QDEPTH];
  logic [ufd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ufd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ufd_pkg::QCNT_W-1:0]    count;

  assign not_full = (count != ufd_pkg::QCNT_W'(ufd_pkg::QDEPTH));
  assign q_valid  = (count != '0);
  assign q_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/ufd_back.sv =====
// Result stage: turns queued jobs into output beats through an output register.
`timescale 1ns / 1ps

module ufd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  ufd_pkg::entry_t             q_entry,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_byte,
  output logic                        out_in_value,
  output logic [ufd_pkg::PAIRS_W-1:0] out_pairs,
  output logic                        out_last
);

  ufd_pkg::entry_t cur;
  logic            second;
  logic            to_second;

  // first beat of a double job leaves; hold the job and show form done next
  assign to_second = out_valid && out_ready && !second && cur.two;
  assign pop       = q_valid && !to_second && (!out_valid || out_ready);

  assign out_kind     = second ? ufd_pkg::KIND_DONE : cur.kind;
  assign out_byte     = second ? 8'h00 : cur.data;
  assign out_in_value = second ? 1'b0 : cur.in_value;
  assign out_pairs    = cur.pairs;
  assign out_last     = second || !cur.two;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (to_second) begin
      second <= 1'b1;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_valid;
      second    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_entry;
  end

endmodule

// ===== design/urlencoded_form_decoder_core.sv =====
// Top level of the URL-encoded form decoder.
//
// Input channel: one raw form byte per beat on in_byte (in_valid/in_ready).
// A zero byte ends the form. Output channel: one result per beat
// (out_valid/out_ready): decoded byte tagged name or value, pair complete,
// form done or form error, with the running pair count; out_last marks the
// final result caused by an input byte.
// Throughput: one input byte per cycle while the job queue has a free slot.
// A byte that ends a form inside a value gives two results and holds the
// result stage until its second result has left. The accepting edge writes
// the byte's job into the job queue; the job then loads the output register,
// which makes the first result of the byte valid. The 4-entry job queue sets
// how far the front end can run ahead.
// When the receiver stalls, the output register holds its beat, the queue
// fills and in_ready drops once it is full. Bytes that give no result still
// need a free slot to be taken.
// Reset (rst, synchronous) empties the queue and output register and puts
// the parser at the start of a form.
`timescale 1ns / 1ps

module urlencoded_form_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_byte,
  output logic                        out_in_value,
  output logic [ufd_pkg::PAIRS_W-1:0] out_pairs,
  output logic                        out_last
);

  logic            push;
  ufd_pkg::entry_t push_entry;
  logic            not_full;
  logic            q_valid;
  ufd_pkg::entry_t q_entry;
  logic            pop;

  ufd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .q_ready    (not_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ufd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (not_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  ufd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_in_value (out_in_value),
    .out_pairs    (out_pairs),
    .out_last     (out_last)
  );

endmodule

// ===== design/ufd_checker.sv =====
// Port-level checker for the URL-encoded form decoder, bound to the top level.
`timescale 1ns / 1ps

module ufd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [7:0]                  in_byte,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [7:0]                  out_byte,
  input logic                        out_in_value,
  input logic [ufd_pkg::PAIRS_W-1:0] out_pairs,
  input logic                        out_last
);

  // Nothing comes out right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_pairs) && $stable(out_last))
    else $error("stalled result beat changed");

  // Only a pair-complete beat can be followed by another result of the same byte.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != ufd_pkg::KIND_PAIR |-> out_last)
    else $error("non-pair result not marked last");

  // A pair complete that is not last is followed by form done with the same count.
  a_pair_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind == ufd_pkg::KIND_PAIR && !out_last
      |=> out_valid && out_kind == ufd_pkg::KIND_DONE && out_last && $stable(out_pairs))
    else $error("pair complete at form end not followed by form done");

  // Only decoded bytes carry data.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != ufd_pkg::KIND_DATA |-> out_byte == 8'h00 && !out_in_value)
    else $error("control result carries a data byte");

endmodule

bind urlencoded_form_decoder_core ufd_checker u_ufd_checker (.*);

// ===== tb/tb_urlencoded_form_decoder_core.sv =====
// Self-checking testbench for the URL-encoded form decoder core.
`timescale 1ns / 1ps

module tb_urlencoded_form_decoder_core;
  import ufd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 157;

  typedef struct {
    kind_t              kind;
    logic [7:0]         data;
    logic               in_value;
    logic [PAIRS_W-1:0] pairs;
    logic               last;
  } form_result_t;

  // Tracks the parser state for every accepted beat and holds the results it owes.
  class form_scoreboard;
    phase_t             phase;
    esc_t               esc;
    logic [3:0]         high_nibble;
    int                 name_len;
    int                 value_len;
    logic [PAIRS_W-1:0] pair_count;
    form_result_t       pending_results[$];
    int                 failures;

    function new();
      failures = 0;
      form_end();
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function void form_end();
      phase       = PH_START;
      esc         = ESC_NONE;
      high_nibble = '0;
      name_len    = 0;
      value_len   = 0;
      pair_count  = '0;
    endfunction

    function void emit(kind_t kind, logic [7:0] data, logic in_value);
      form_result_t r;
      r.kind     = kind;
      r.data     = data;
      r.in_value = in_value;
      r.pairs    = pair_count;
      r.last     = 1'b0;
      pending_results.push_back(r);
    endfunction

    // Drop decoded zeros and anything past the field limit.
    function void emit_data(logic [7:0] ch);
      if (ch == CH_NUL) return;
      if (phase == PH_VALUE) begin
        if (value_len >= VALUE_BYTES - 1) return;
        value_len++;
        emit(KIND_DATA, ch, 1'b1);
      end else begin
        if (name_len >= NAME_BYTES - 1) return;
        name_len++;
        emit(KIND_DATA, ch, 1'b0);
      end
    endfunction

    function void pair_done();
      if (pair_count != PAIRS_MAX) pair_count++;
      emit(KIND_PAIR, 8'h00, 1'b0);
    endfunction

    function void form_error(logic [7:0] b);
      emit(KIND_ERROR, 8'h00, 1'b0);
      if (b == CH_NUL) begin
        form_end();
      end else begin
        phase = PH_SWALLOW;
        esc   = ESC_NONE;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int first;
      int h;
      first = pending_results.size();
      if (phase == PH_SWALLOW) begin
        if (b == CH_NUL) form_end();
        return;
      end
      if (esc == ESC_HI) begin
        h = hex_nibble(b);
        if (h < 0) begin
          form_error(b);
        end else begin
          high_nibble = h[3:0];
          esc = ESC_LO;
        end
      end else if (esc == ESC_LO) begin
        h = hex_nibble(b);
        if (h < 0) begin
          form_error(b);
        end else begin
          esc = ESC_NONE;
          emit_data({high_nibble, h[3:0]});
        end
      end else if (b == CH_NUL) begin
        if (phase == PH_START) begin
          emit(KIND_DONE, 8'h00, 1'b0);
          form_end();
        end else if (phase == PH_VALUE) begin
          pair_done();
          emit(KIND_DONE, 8'h00, 1'b0);
          form_end();
        end else begin
          form_error(CH_NUL);
        end
      end else begin
        if (phase == PH_START || phase == PH_AFTER_AMP) begin
          phase = PH_NAME;
          name_len = 0;
        end
        if (phase == PH_NAME && b == CH_EQ) begin
          phase = PH_VALUE;
          value_len = 0;
        end else if (phase == PH_VALUE && b == CH_AMP) begin
          pair_done();
          phase = PH_AFTER_AMP;
          name_len = 0;
        end else if (b == CH_PCT) begin
          esc = ESC_HI;
        end else if (b == CH_PLUS) begin
          emit_data(CH_SPACE);
        end else begin
          emit_data(b);
        end
      end
      if (pending_results.size() > first) begin
        pending_results[pending_results.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic in_value,
                               logic [PAIRS_W-1:0] pairs, logic last);
      form_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d byte %02h", kind, data);
        failures++;
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind) begin
        $error("out_kind: expected %0d, got %0d", e.kind, kind);
        failures++;
      end
      if (data !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, data);
        failures++;
      end
      if (in_value !== e.in_value) begin
        $error("out_in_value: expected %0d, got %0d", e.in_value, in_value);
        failures++;
      end
      if (pairs !== e.pairs) begin
        $error("out_pairs: expected %0d, got %0d", e.pairs, pairs);
        failures++;
      end
      if (last !== e.last) begin
        $error("out_last: expected %0d, got %0d", e.last, last);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [7:0]         out_byte;
  logic               out_in_value;
  logic [PAIRS_W-1:0] out_pairs;
  logic               out_last;

  form_scoreboard sb;
  int             send_idle = 34;
  int             recv_idle = 54;
  int             accepted_items = 0;
  int             stall_cycles = 0;
  logic [7:0]     form_bytes[$];

  urlencoded_form_decoder_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_in_value (out_in_value),
    .out_pairs    (out_pairs),
    .out_last     (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_kind, out_byte, out_in_value, out_pairs, out_last);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    sb.note_byte(b);
    accepted_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_form();
    foreach (form_bytes[i]) send_byte(form_bytes[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_escape(logic [7:0] v);
    form_bytes.push_back(CH_PCT);
    form_bytes.push_back(hex_char(v[7:4]));
    form_bytes.push_back(hex_char(v[3:0]));
  endfunction

  // Content for a name or a value; never ends the field early.
  function automatic void add_field(bit in_value);
    int         len;
    int         roll;
    logic [7:0] c;
    logic [7:0] term;
    logic [7:0] other;
    term  = in_value ? CH_AMP : CH_EQ;
    other = in_value ? CH_EQ : CH_AMP;
    len   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        c = 8'($urandom_range(33, 126));
        if (c == term || c == CH_PCT) c = "z";
        form_bytes.push_back(c);
      end else if (roll < 55) begin
        form_bytes.push_back(CH_PLUS);
      end else if (roll < 75) begin
        add_escape(8'($urandom_range(255)));
      end else if (roll < 80) begin
        add_escape(8'h00);
      end else if (roll < 85) begin
        add_escape($urandom_range(1) ? CH_EQ : CH_AMP);
      end else if (roll < 95) begin
        c = 8'($urandom_range(1, 255));
        if (c == term || c == CH_PCT) c = 8'h7F;
        form_bytes.push_back(c);
      end else begin
        form_bytes.push_back(other);
      end
    end
  endfunction

  function automatic void add_pairs(int count);
    for (int i = 0; i < count; i++) begin
      if (i > 0) form_bytes.push_back(CH_AMP);
      add_field(1'b0);
      form_bytes.push_back(CH_EQ);
      add_field(1'b1);
    end
  endfunction

  function automatic void add_bad_escape();
    logic [7:0] c;
    form_bytes.push_back(CH_PCT);
    if ($urandom_range(1)) form_bytes.push_back(hex_char(4'($urandom_range(15))));
    case ($urandom_range(3))
      0: c = CH_NUL;
      1: c = CH_EQ;
      2: c = CH_AMP;
      default: begin
        c = 8'($urandom_range(1, 255));
        while (sb.hex_nibble(c) >= 0) c = 8'($urandom_range(1, 255));
      end
    endcase
    form_bytes.push_back(c);
    if (c != CH_NUL) begin
      repeat ($urandom_range(6)) form_bytes.push_back(8'($urandom_range(1, 255)));
      form_bytes.push_back(CH_NUL);
    end
  endfunction

  function automatic void make_form();
    int roll;
    form_bytes.delete();
    roll = $urandom_range(99);
    if (roll < 78) begin
      add_pairs($urandom_range(4));
      form_bytes.push_back(CH_NUL);
    end else if (roll < 90) begin
      add_pairs($urandom_range(1, 3));
      case ($urandom_range(3))
        0: form_bytes.push_back(CH_AMP);
        1: begin
          form_bytes.push_back(CH_AMP);
          add_field(1'b0);
          form_bytes.push_back("n");
        end
        2: begin
          add_bad_escape();
          return;
        end
        default: begin
          form_bytes.push_back(CH_PCT);
          if ($urandom_range(1)) form_bytes.push_back(hex_char(4'($urandom_range(15))));
        end
      endcase
      form_bytes.push_back(CH_NUL);
    end else if (roll < 94) begin
      add_bad_escape();
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(4))
          0: form_bytes.push_back(CH_EQ);
          1: form_bytes.push_back(CH_AMP);
          2: form_bytes.push_back(CH_PCT);
          default: form_bytes.push_back(8'($urandom_range(255)));
        endcase
      end
      form_bytes.push_back(CH_NUL);
    end
  endfunction

  // Overrun the name limit, with a decoded zero and a late escape in the name.
  task automatic send_limit_form();
    form_bytes.delete();
    for (int i = 0; i < NAME_BYTES + 6; i++) begin
      if (i == 5) add_escape(8'h00);
      form_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
    add_escape(8'h41);
    form_bytes.push_back(CH_EQ);
    for (int i = 0; i < 12; i++) begin
      form_bytes.push_back($urandom_range(3) == 0 ? CH_PLUS : 8'($urandom_range(8'h41, 8'h5A)));
    end
    add_escape(8'h42);
    form_bytes.push_back(CH_NUL);
    send_form();
  endtask

  initial begin
    int phase_idx;
    int goal;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
      case (phase_idx)
        0: begin
          send_idle = 34;
          recv_idle = 54;
        end
        1: begin
          send_idle = 54;
          recv_idle = 34;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase

      if (phase_idx == 0) begin
        // empty form
        send_byte(CH_NUL);
        // raw extremes, escapes of both cases, plus, decoded zero, two-result end
        send_byte(8'h01);
        send_text("%3d+=");
        send_byte(8'hFF);
        send_text("%Ac%00");
        send_byte(CH_NUL);
        // trailing ampersand
        send_text("=&");
        send_byte(CH_NUL);
        // name with no equals sign
        send_text("n");
        send_byte(CH_NUL);
        // bad escape, then swallow up to the terminator
        send_text("%Gq");
        send_byte(CH_NUL);
        // escape cut short by the terminator
        send_text("%4");
        send_byte(CH_NUL);
      end

      if (phase_idx == 2) begin
        send_limit_form();
      end

      goal = accepted_items + PHASE_ITEMS;
      while (accepted_items < goal) begin
        make_form();
        send_form();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ufd_pkg.sv
design/ufd_front.sv
design/ufd_queue.sv
design/ufd_back.sv
design/urlencoded_form_decoder_core.sv
design/ufd_checker.sv
tb/tb_urlencoded_form_decoder_core.sv
